[rtl/core/vism_pkg.sv]
// Shared types and constants for the virtual interrupt slot manager.
`default_nettype none
package vism_pkg;
    localparam int GUESTS      = 2;
    localparam int LIST_SLOTS  = 16;
    localparam int QUEUE_DEPTH = 128;
    localparam int FLUSH_LIMIT = 16;
    localparam int GW   = 1;
    localparam int SW   = 4;
    localparam int QW   = 7;
    localparam int IRQW = 10;
    localparam int TAW  = GW + SW;
    localparam int QAW  = GW + QW;

    typedef enum logic [1:0] {
        OP_INJECT = 2'd0,
        OP_EOI    = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_INJECT = 2'd0,
        KIND_FILL   = 2'd1,
        KIND_EOI    = 2'd2,
        KIND_FLUSH  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIRECT,
        ST_DUP_RD,
        ST_DUP_CHK,
        ST_QSCAN,
        ST_EOI_RD,
        ST_EOI_DONE,
        ST_FL_CHK,
        ST_FL_PLACE,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic [TAW-1:0]  rd_addr;
        logic            wr_virq;
        logic            wr_pirq;
        logic            clr;
        logic [TAW-1:0]  wr_addr;
        logic [IRQW-1:0] virq;
        logic [IRQW-1:0] pirq;
    } tbl_req_t;

    typedef struct packed {
        logic            vvalid;
        logic [IRQW-1:0] virq;
        logic            pvalid;
        logic [IRQW-1:0] pirq;
    } tbl_rsp_t;

    typedef struct packed {
        logic            wr;
        logic            clr;
        logic [QAW-1:0]  addr;
        logic [IRQW-1:0] virq;
        logic [IRQW-1:0] pirq;
        logic            hw;
    } q_req_t;

    typedef struct packed {
        logic            chk_valid;
        logic [IRQW-1:0] virq;
        logic [IRQW-1:0] pirq;
        logic            hw;
    } q_rsp_t;

    typedef struct packed {
        kind_t           kind;
        logic            status;
        logic [SW-1:0]   slot;
        logic [IRQW-1:0] virq;
        logic [IRQW-1:0] pirq;
        logic            pv;
        logic            hw;
        logic [4:0]      count;
        logic            last;
    } res_t;
endpackage
`default_nettype wire

[rtl/core/vism_tables.sv]
// Per-guest slot tables: virq and pirq memories with per-entry valid bits.
`default_nettype none
module vism_tables (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire vism_pkg::tbl_req_t req,
    output vism_pkg::tbl_rsp_t      rsp
);
    import vism_pkg::*;

    localparam int ENTRIES = GUESTS * LIST_SLOTS;

    logic [IRQW-1:0] virq_mem [ENTRIES];
    logic [IRQW-1:0] pirq_mem [ENTRIES];
    logic [ENTRIES-1:0] vvalid_reg;
    logic [ENTRIES-1:0] pvalid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_virq) begin
            virq_mem[req.wr_addr] <= req.virq;
        end
        if (req.wr_pirq) begin
            pirq_mem[req.wr_addr] <= req.pirq;
        end
        rsp.virq   <= virq_mem[req.rd_addr];
        rsp.pirq   <= pirq_mem[req.rd_addr];
        rsp.vvalid <= vvalid_reg[req.rd_addr];
        rsp.pvalid <= pvalid_reg[req.rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vvalid_reg <= '0;
            pvalid_reg <= '0;
        end else begin
            if (req.clr) begin
                vvalid_reg[req.wr_addr] <= 1'b0;
                pvalid_reg[req.wr_addr] <= 1'b0;
            end
            if (req.wr_virq) begin
                vvalid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.wr_pirq) begin
                pvalid_reg[req.wr_addr] <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/vism_queue.sv]
// Pending queues of all guests: entry memory plus per-entry valid flops.
`default_nettype none
module vism_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire vism_pkg::q_req_t req,
    output vism_pkg::q_rsp_t      rsp
);
    import vism_pkg::*;

    localparam int ENTRIES = GUESTS * QUEUE_DEPTH;
    localparam int DW = 2 * IRQW + 1;

    logic [DW-1:0]      q_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [DW-1:0]      rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr) begin
            q_mem[req.addr] <= {req.hw, req.pirq, req.virq};
        end
        rd_data_reg <= q_mem[req.addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.wr) begin
            valid_reg[req.addr] <= 1'b1;
        end else if (req.clr) begin
            valid_reg[req.addr] <= 1'b0;
        end
    end

    assign rsp.chk_valid = valid_reg[req.addr];
    assign rsp.virq      = rd_data_reg[IRQW-1:0];
    assign rsp.pirq      = rd_data_reg[2*IRQW-1:IRQW];
    assign rsp.hw        = rd_data_reg[DW-1];
endmodule
`default_nettype wire

[rtl/core/virtual_irq_slot_manager_unit.sv]
// Top level of the virtual interrupt slot manager: control sequencer and ports.
// Direct inject writes the lowest free slot; eoi reads, then frees a slot; queued inject
//   does a duplicate scan of the 16 slot entries, then a queue scan.
// Flush walks the queue and places each valid entry into the lowest free slot.
// One request in flight at a time; the next is taken once the last result of
// the current one sits in the output register. Reset (aresetn, synchronous)
// frees all slots, invalidates all table and queue entries at once.
`default_nettype none
module virtual_irq_slot_manager_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // guest, virq[10:1], pirq[20:11], is_hw, eoi_slot[25:22]
    input  wire logic [1:0]  s_tuser,   // op
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // status, slot[4:1], virq_out[14:5], pirq_out[24:15],
                                        // pirq_valid, hw_out, count[31:27]
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [4:0]  cfg_wdata
);
    import vism_pkg::*;

    state_t state_reg, state_next;

    // latched request
    logic            g_reg,    g_next;
    logic [IRQW-1:0] virq_reg, virq_next;
    logic [IRQW-1:0] pirq_reg, pirq_next;
    logic            hw_reg,   hw_next;
    logic [SW-1:0]   eslot_reg, eslot_next;

    logic [QW:0]     cnt_reg, cnt_next;       // scan index, top bit = end of queue
    logic [4:0]      placed_reg, placed_next;
    res_t            res_reg, res_next;
    logic [LIST_SLOTS-1:0] busy_reg, busy_next;

    logic            rg_reg;                  // running guest
    logic [4:0]      slots_reg;               // slots in use

    // output register
    logic            m_valid_reg;
    res_t            m_res_reg;

    tbl_req_t tbl_req;
    tbl_rsp_t tbl_rsp;
    q_req_t   q_req;
    q_rsp_t   q_rsp;

    logic [4:0]    usable;
    logic          lf_found;
    logic [SW-1:0] lf_slot;
    logic          out_free;
    logic          accept;
    op_t           in_op;
    logic [SW-1:0] in_eslot;

    assign in_op    = op_t'(s_tuser);
    assign in_eslot = s_tdata[25:22];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // slots above the list size act as the list size
    assign usable = (slots_reg > 5'(LIST_SLOTS)) ? 5'(LIST_SLOTS) : slots_reg;

    // lowest free usable slot
    always_comb begin
        lf_found = 1'b0;
        lf_slot  = '0;
        for (int i = LIST_SLOTS - 1; i >= 0; i--) begin
            if ((5'(i) < usable) && !busy_reg[i]) begin
                lf_found = 1'b1;
                lf_slot  = SW'(i);
            end
        end
    end

    vism_tables u_tables (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rsp     (tbl_rsp)
    );

    vism_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (q_req),
        .rsp     (q_rsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_INJECT: state_next = (s_tdata[0] == rg_reg) ? ST_DIRECT : ST_DUP_RD;
                        OP_EOI:    state_next = ({1'b0, in_eslot} >= usable) ? ST_SEND
                                                                             : ST_EOI_RD;
                        OP_FLUSH:  state_next = ST_FL_CHK;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIRECT:  state_next = ST_SEND;
            ST_DUP_RD:  state_next = ST_DUP_CHK;
            ST_DUP_CHK: begin
                if (tbl_rsp.vvalid && tbl_rsp.virq == virq_reg) begin
                    state_next = ST_SEND;
                end else if (cnt_reg[SW-1:0] == SW'(LIST_SLOTS - 1)) begin
                    state_next = ST_QSCAN;
                end else begin
                    state_next = ST_DUP_RD;
                end
            end
            ST_QSCAN: begin
                if (!q_rsp.chk_valid || cnt_reg[QW-1:0] == QW'(QUEUE_DEPTH - 1)) begin
                    state_next = ST_SEND;
                end
            end
            ST_EOI_RD:   state_next = ST_EOI_DONE;
            ST_EOI_DONE: state_next = ST_SEND;
            ST_FL_CHK: begin
                if (cnt_reg[QW]) begin
                    state_next = ST_SEND;
                end else if (q_rsp.chk_valid) begin
                    if (placed_reg == 5'(FLUSH_LIMIT) || !lf_found) begin
                        state_next = ST_SEND;
                    end else begin
                        state_next = ST_FL_PLACE;
                    end
                end
            end
            ST_FL_PLACE: state_next = ST_SEND;
            ST_SEND: begin
                if (out_free) begin
                    state_next = res_reg.last ? ST_IDLE : ST_FL_CHK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        g_next      = g_reg;
        virq_next   = virq_reg;
        pirq_next   = pirq_reg;
        hw_next     = hw_reg;
        eslot_next  = eslot_reg;
        cnt_next    = cnt_reg;
        placed_next = placed_reg;
        res_next    = res_reg;
        busy_next   = busy_reg;

        tbl_req         = '0;
        tbl_req.rd_addr = {g_reg, cnt_reg[SW-1:0]};
        tbl_req.wr_addr = {g_reg, lf_slot};
        tbl_req.virq    = virq_reg;
        tbl_req.pirq    = pirq_reg;

        q_req      = '0;
        q_req.addr = {g_reg, cnt_reg[QW-1:0]};
        q_req.virq = virq_reg;
        q_req.pirq = pirq_reg;
        q_req.hw   = hw_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    g_next      = s_tdata[0];
                    virq_next   = s_tdata[10:1];
                    pirq_next   = s_tdata[20:11];
                    hw_next     = s_tdata[21];
                    eslot_next  = in_eslot;
                    cnt_next    = '0;
                    placed_next = '0;
                    // eoi beyond the usable slots: refused, nothing changes
                    res_next        = '0;
                    res_next.kind   = KIND_EOI;
                    res_next.status = 1'b1;
                    res_next.slot   = in_eslot;
                    res_next.last   = 1'b1;
                end
            end
            ST_DIRECT: begin
                res_next      = '0;
                res_next.kind = KIND_INJECT;
                res_next.last = 1'b1;
                if (lf_found) begin
                    busy_next[lf_slot] = 1'b1;
                    tbl_req.wr_virq    = 1'b1;
                    tbl_req.wr_pirq    = hw_reg;
                    res_next.slot      = lf_slot;
                    res_next.virq      = virq_reg;
                    res_next.pirq      = hw_reg ? pirq_reg : '0;
                    res_next.pv        = hw_reg;
                    res_next.hw        = hw_reg;
                end else begin
                    res_next.status = 1'b1;
                end
            end
            ST_DUP_CHK: begin
                res_next        = '0;
                res_next.kind   = KIND_INJECT;
                res_next.status = 1'b1;
                res_next.last   = 1'b1;
                if (cnt_reg[SW-1:0] == SW'(LIST_SLOTS - 1)) begin
                    cnt_next = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_QSCAN: begin
                res_next      = '0;
                res_next.kind = KIND_INJECT;
                res_next.last = 1'b1;
                if (!q_rsp.chk_valid) begin
                    q_req.wr = 1'b1;
                end else begin
                    res_next.status = 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                end
            end
            ST_EOI_RD: begin
                tbl_req.rd_addr = {rg_reg, eslot_reg};
            end
            ST_EOI_DONE: begin
                busy_next[eslot_reg] = 1'b0;
                tbl_req.clr          = 1'b1;
                tbl_req.wr_addr      = {rg_reg, eslot_reg};
                res_next             = '0;
                res_next.kind        = KIND_EOI;
                res_next.slot        = eslot_reg;
                res_next.virq        = tbl_rsp.vvalid ? tbl_rsp.virq : '0;
                res_next.pirq        = tbl_rsp.pvalid ? tbl_rsp.pirq : '0;
                res_next.pv          = tbl_rsp.pvalid;
                res_next.last        = 1'b1;
            end
            ST_FL_CHK: begin
                res_next       = '0;
                res_next.kind  = KIND_FLUSH;
                res_next.count = placed_reg;
                res_next.last  = 1'b1;
                if (!cnt_reg[QW] && !q_rsp.chk_valid) begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FL_PLACE: begin
                busy_next[lf_slot] = 1'b1;
                tbl_req.wr_virq    = 1'b1;
                tbl_req.wr_pirq    = q_rsp.hw;
                tbl_req.virq       = q_rsp.virq;
                tbl_req.pirq       = q_rsp.pirq;
                q_req.clr          = 1'b1;
                cnt_next           = cnt_reg + 1'b1;
                placed_next        = placed_reg + 1'b1;
                res_next           = '0;
                res_next.kind      = KIND_FILL;
                res_next.slot      = lf_slot;
                res_next.virq      = q_rsp.virq;
                res_next.pirq      = q_rsp.hw ? q_rsp.pirq : '0;
                res_next.pv        = q_rsp.hw;
                res_next.hw        = q_rsp.hw;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            busy_reg    <= '0;
            rg_reg      <= 1'b0;
            slots_reg   <= 5'd4;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            if (cfg_wr_en) begin
                if (cfg_addr) begin
                    slots_reg <= cfg_wdata;
                end else begin
                    rg_reg <= cfg_wdata[0];
                end
            end
            if (state_reg == ST_SEND && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        g_reg      <= g_next;
        virq_reg   <= virq_next;
        pirq_reg   <= pirq_next;
        hw_reg     <= hw_next;
        eslot_reg  <= eslot_next;
        cnt_reg    <= cnt_next;
        placed_reg <= placed_next;
        res_reg    <= res_next;
        if (state_reg == ST_SEND && out_free) begin
            m_res_reg <= res_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {m_res_reg.count, m_res_reg.hw, m_res_reg.pv, m_res_reg.pirq,
                       m_res_reg.virq, m_res_reg.slot, m_res_reg.status};
endmodule
`default_nettype wire

[dv/tb_virtual_irq_slot_manager_unit.sv]
// Testbench for the virtual interrupt slot manager: directed, random, then queue-full.
`timescale 1ns / 1ps
module tb_virtual_irq_slot_manager_unit;
    import vism_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int CYCLE_CAP  = 1000000;
    localparam int DRAIN_WAIT = 400;
    localparam logic CFG_GUEST = 1'b0;   // running_guest register
    localparam logic CFG_SLOTS = 1'b1;   // slots_in_use register

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = CFG_GUEST;
    logic [4:0]  cfg_wdata = '0;

    virtual_irq_slot_manager_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    typedef struct {
        op_t         op;
        logic        guest;
        logic [9:0]  virq;
        logic [9:0]  pirq;
        logic        hw;
        logic [3:0]  eslot;
    } irq_req_t;

    typedef struct {
        logic [4:0] cfg_slots;   // nonzero: write slots_in_use before the row
        irq_req_t   req;
        logic       has_exp;     // typed-in expectation present
        res_t       exp;
    } row_t;

    typedef struct {
        logic       valid;
        logic [9:0] virq;
        logic [9:0] pirq;
        logic       hw;
    } qent_t;

    // predictor state
    logic        mdl_guest;
    logic [4:0]  mdl_slots;
    logic        busy_map [LIST_SLOTS];
    logic [10:0] virq_tbl [GUESTS][LIST_SLOTS];
    logic [10:0] pirq_tbl [GUESTS][LIST_SLOTS];
    qent_t       pend_q   [GUESTS][QUEUE_DEPTH];

    res_t   results_due[$];
    int     errors = 0;
    int     cycles = 0;
    int     src_idle_pct = 0;
    int     snk_idle_pct = 0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("virtual_irq_slot_manager_unit regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function automatic int usable();
        return (mdl_slots > LIST_SLOTS) ? LIST_SLOTS : int'(mdl_slots);
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < usable(); i++)
            if (!busy_map[i]) return i;
        return -1;
    endfunction

    function automatic res_t mk(kind_t k, logic st, int sl, logic [9:0] v, logic [9:0] p,
                                logic pv, logic hw, int cnt, logic lst);
        res_t r;
        r.kind = k; r.status = st; r.slot = sl[3:0]; r.virq = v;
        r.pirq = pv ? p : '0; r.pv = pv; r.hw = hw; r.count = cnt[4:0]; r.last = lst;
        return r;
    endfunction

    task automatic occupy(int g, int s, logic [9:0] v, logic [9:0] p, logic hw);
        busy_map[s] = 1'b1;
        if (hw) pirq_tbl[g][s] = {1'b1, p};
        virq_tbl[g][s] = {1'b1, v};
    endtask

    // computes the results of one request and updates predictor state
    task automatic predict_request(input irq_req_t r);
        int s;
        int placed;
        logic dup;
        logic queued;
        case (r.op)
            OP_INJECT: begin
                if (r.guest == mdl_guest) begin
                    s = first_free_slot();
                    if (s < 0) results_due.push_back(mk(KIND_INJECT, 1, 0, 0, 0, 0, 0, 0, 1));
                    else begin
                        occupy(r.guest, s, r.virq, r.pirq, r.hw);
                        results_due.push_back(mk(KIND_INJECT, 0, s, r.virq, r.pirq,
                                                 r.hw, r.hw, 0, 1));
                    end
                end else begin
                    dup = 1'b0;
                    for (int i = 0; i < LIST_SLOTS; i++)
                        if (virq_tbl[r.guest][i][10] && virq_tbl[r.guest][i][9:0] == r.virq)
                            dup = 1'b1;
                    queued = 1'b0;
                    if (!dup)
                        for (int i = 0; i < QUEUE_DEPTH && !queued; i++)
                            if (!pend_q[r.guest][i].valid) begin
                                pend_q[r.guest][i] = '{1'b1, r.virq, r.pirq, r.hw};
                                queued = 1'b1;
                            end
                    results_due.push_back(mk(KIND_INJECT, !queued, 0, 0, 0, 0, 0, 0, 1));
                end
            end
            OP_EOI: begin
                if (int'(r.eslot) >= usable())
                    results_due.push_back(mk(KIND_EOI, 1, r.eslot, 0, 0, 0, 0, 0, 1));
                else begin
                    busy_map[r.eslot] = 1'b0;
                    results_due.push_back(mk(KIND_EOI, 0, r.eslot,
                        virq_tbl[mdl_guest][r.eslot][10] ? virq_tbl[mdl_guest][r.eslot][9:0] : '0,
                        pirq_tbl[mdl_guest][r.eslot][9:0], pirq_tbl[mdl_guest][r.eslot][10],
                        0, 0, 1));
                    virq_tbl[mdl_guest][r.eslot] = '0;
                    pirq_tbl[mdl_guest][r.eslot] = '0;
                end
            end
            OP_FLUSH: begin
                placed = 0;
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (pend_q[r.guest][i].valid) begin
                        if (placed >= FLUSH_LIMIT) break;
                        s = first_free_slot();
                        if (s < 0) break;
                        occupy(r.guest, s, pend_q[r.guest][i].virq, pend_q[r.guest][i].pirq,
                               pend_q[r.guest][i].hw);
                        results_due.push_back(mk(KIND_FILL, 0, s, pend_q[r.guest][i].virq,
                            pend_q[r.guest][i].pirq, pend_q[r.guest][i].hw,
                            pend_q[r.guest][i].hw, 0, 0));
                        pend_q[r.guest][i].valid = 1'b0;
                        placed++;
                    end
                end
                results_due.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 0, 0, placed, 1));
            end
            default: ;   // unused op: no result
        endcase
    endtask

    // result side: random stall, compare against oldest expectation
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = mk(kind_t'(m_tuser), m_tdata[0], m_tdata[4:1], m_tdata[14:5], m_tdata[24:15],
                     m_tdata[25], m_tdata[26], m_tdata[31:27], m_tlast);
            got.pirq = m_tdata[24:15];
            if (results_due.size() == 0)
                report_mismatch($sformatf("unexpected result kind=%0d", m_tuser));
            else begin
                want = results_due.pop_front();
                if (got.kind != want.kind)     report_mismatch("kind");
                if (got.status != want.status) report_mismatch("status");
                if (got.slot != want.slot)     report_mismatch("slot");
                if (got.virq != want.virq)     report_mismatch("virq_out");
                if (got.pirq != want.pirq)     report_mismatch("pirq_out");
                if (got.pv != want.pv)         report_mismatch("pirq_valid");
                if (got.hw != want.hw)         report_mismatch("hw_out");
                if (got.count != want.count)   report_mismatch("count");
                if (got.last != want.last)     report_mismatch("last");
            end
        end
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic write_cfg(input logic idx, input logic [4:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_GUEST) mdl_guest = val[0];
        else                  mdl_slots = val;
    endtask

    // wait for every expected result, then the block's worst-case tail
    task automatic settle();
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // pushes one request through the handshake, then drops tvalid
    task automatic send_request(input irq_req_t r, input logic has_exp, input res_t exp);
        while ($urandom_range(99) < src_idle_pct) begin
            @(posedge aclk);
            s_tvalid <= 1'b0;
        end
        predict_request(r);
        if (has_exp && results_due.size() != 0 && results_due[$] != exp)
            report_mismatch("typed-in expectation disagrees with predictor");
        @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {6'd0, r.eslot, r.hw, r.pirq, r.virq, r.guest};
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
    endtask

    function automatic irq_req_t rq(op_t o, logic g, int v, int p, logic hw, int es);
        irq_req_t r;
        r.op = o; r.guest = g; r.virq = v[9:0]; r.pirq = p[9:0]; r.hw = hw; r.eslot = es[3:0];
        return r;
    endfunction

    function automatic irq_req_t random_request();
        irq_req_t r;
        int pick;
        pick = $urandom_range(99);
        r = rq(OP_INJECT, 1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023),
               1'($urandom_range(1)), $urandom_range(15));
        // small virq pool for some injects so duplicates show up
        if ($urandom_range(3) == 0) r.virq = 10'($urandom_range(7));
        if (pick < 50)      r.op = OP_INJECT;
        else if (pick < 78) r.op = OP_EOI;
        else if (pick < 96) r.op = OP_FLUSH;
        else                r.op = OP_NONE;
        return r;
    endfunction

    row_t dir_rows[$];
    res_t none_exp;
    int   slot_pick;

    initial begin
        mdl_guest = 1'b0;
        mdl_slots = 5'd4;
        for (int s = 0; s < LIST_SLOTS; s++) begin
            busy_map[s] = 1'b0;
            for (int g = 0; g < GUESTS; g++) begin
                virq_tbl[g][s] = '0;
                pirq_tbl[g][s] = '0;
            end
        end
        for (int g = 0; g < GUESTS; g++)
            for (int i = 0; i < QUEUE_DEPTH; i++) pend_q[g][i] = '{1'b0, '0, '0, 1'b0};
        none_exp = mk(KIND_INJECT, 0, 0, 0, 0, 0, 0, 0, 1);

        // directed: reset config (guest 0 running, 4 slots)
        dir_rows = '{
            '{0, rq(OP_EOI,    0, 0,    0,    0, 4),  1, mk(KIND_EOI, 1, 4, 0, 0, 0, 0, 0, 1)},
            '{0, rq(OP_INJECT, 0, 1023, 1023, 1, 0),  1,
                 mk(KIND_INJECT, 0, 0, 1023, 1023, 1, 1, 0, 1)},
            '{0, rq(OP_INJECT, 0, 0,    5,    0, 0),  1, mk(KIND_INJECT, 0, 1, 0, 0, 0, 0, 0, 1)},
            '{0, rq(OP_INJECT, 0, 7,    9,    1, 0),  0, none_exp},
            '{0, rq(OP_INJECT, 0, 8,    9,    0, 0),  0, none_exp},
            '{0, rq(OP_INJECT, 0, 9,    9,    0, 0),  1, mk(KIND_INJECT, 1, 0, 0, 0, 0, 0, 0, 1)},
            '{0, rq(OP_INJECT, 1, 300,  1023, 1, 15), 1, mk(KIND_INJECT, 0, 0, 0, 0, 0, 0, 0, 1)},
            '{0, rq(OP_INJECT, 1, 0,    0,    0, 0),  0, none_exp},
            '{0, rq(OP_FLUSH,  1, 0,    0,    0, 0),  0, none_exp},
            '{0, rq(OP_EOI,    0, 0,    0,    0, 0),  1,
                 mk(KIND_EOI, 0, 0, 1023, 1023, 1, 0, 0, 1)},
            '{0, rq(OP_EOI,    0, 0,    0,    0, 0),  1, mk(KIND_EOI, 0, 0, 0, 0, 0, 0, 0, 1)},
            '{0, rq(OP_FLUSH,  1, 0,    0,    0, 0),  0, none_exp},
            '{0, rq(OP_NONE,   1, 1023, 1023, 1, 15), 0, none_exp},
            '{16, rq(OP_EOI,   0, 0,    0,    0, 15), 0, none_exp},
            '{16, rq(OP_FLUSH, 0, 0,    0,    0, 0),  1, mk(KIND_FLUSH, 0, 0, 0, 0, 0, 0, 0, 1)},
            '{1,  rq(OP_EOI,   0, 0,    0,    0, 1),  1, mk(KIND_EOI, 1, 1, 0, 0, 0, 0, 0, 1)}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 21; snk_idle_pct = 88;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_slots != 0) begin
                settle();
                write_cfg(CFG_SLOTS, dir_rows[i].cfg_slots);
            end
            send_request(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);
        end

        // guest 1 becomes running; its direct injects fill its own table
        settle();
        write_cfg(CFG_GUEST, 1'b1);
        write_cfg(CFG_SLOTS, 5'd31);
        for (int i = 0; i < 4; i++)
            send_request(rq(OP_INJECT, 1, 500 + i, 600 + i, i[0], 0), 0, none_exp);

        // random phases: each picks a setting, then well-formed bursts
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            if (ph == 2) begin src_idle_pct = 88; snk_idle_pct = 21; end
            if (ph == 4) begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            write_cfg(CFG_GUEST, 5'($urandom_range(1)));
            case (ph % 3)
                0: slot_pick = 16;
                1: slot_pick = $urandom_range(1, 3);
                default: slot_pick = $urandom_range(0, 31);
            endcase
            write_cfg(CFG_SLOTS, slot_pick[4:0]);
            for (int n = 0; n < 35; n++)
                send_request(random_request(), 0, none_exp);
        end
        // fill one guest queue past its depth to hit the full case
        settle();
        write_cfg(CFG_GUEST, 1'b0);
        write_cfg(CFG_SLOTS, 5'd1);
        for (int n = 0; n < QUEUE_DEPTH + 2; n++)
            send_request(rq(OP_INJECT, 1, 16 + n, n, n[0], 0), 0, none_exp);
        settle();
        write_cfg(CFG_SLOTS, 5'd16);
        for (int n = 0; n < 3; n++) send_request(rq(OP_FLUSH, 1, 0, 0, 0, 0), 0, none_exp);

        settle();
        if (errors == 0 && results_due.size() == 0) begin
            $display("virtual_irq_slot_manager_unit regression: pass");
        end else begin
            $display("virtual_irq_slot_manager_unit regression: fail");
        end
        $finish;
    end
endmodule
